// ----- rtl/mau_pkg.sv -----
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Shared widths, opcodes, reset values and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mau_pkg;

  // Fixed field widths of the item and configuration ports.
  localparam int FIELD_W   = 31;
  localparam int OPC_W     = 4;
  localparam int WIDE_W    = 64;
  localparam int MUL_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BARRETT = 1'b1;

  // Register values after reset.
  localparam logic [FIELD_W-1:0] MODULUS_RST = 31'd1000000007;
  localparam logic [CFG_W-1:0]   BARRETT_RST = 64'd18446743944;

  typedef enum logic [OPC_W-1:0] {
    OP_REDUCE = 4'd0,
    OP_ADD    = 4'd1,
    OP_SUB    = 4'd2,
    OP_MUL    = 4'd3,
    OP_DIV    = 4'd4,
    OP_NEG    = 4'd5,
    OP_INC    = 4'd6,
    OP_DEC    = 4'd7,
    OP_INV    = 4'd8,
    OP_POW    = 4'd9
  } op_e;

  // Operand selection for the shared divider.
  typedef enum logic [1:0] {
    DIV_SRC_A,
    DIV_SRC_B,
    DIV_SRC_WIDE,
    DIV_SRC_EUC
  } div_src_e;

  // Source of the result register.
  typedef enum logic [2:0] {
    RES_ZERO,
    RES_ALU,
    RES_WRED,
    RES_INV,
    RES_MM,
    RES_ACC
  } res_src_e;

  // Operand pair of a modular multiplication.
  typedef enum logic [1:0] {
    MM_SRC_AB,
    MM_SRC_AINV,
    MM_SRC_ACCB,
    MM_SRC_BB
  } mm_src_e;

  // Steps of one Barrett modular multiplication.
  typedef enum logic [3:0] {
    MM_NONE,
    MM_P0,
    MM_X,
    MM_L0,
    MM_L1,
    MM_L2,
    MM_L3,
    MM_L4,
    MM_Q0,
    MM_Q1,
    MM_Q2,
    MM_FIN
  } mm_step_e;

  typedef struct packed {
    logic     ld_in;
    logic     div_start;
    div_src_e div_src;
    logic     ld_a;
    logic     ld_b;
    logic     res_ld;
    res_src_e res_src;
    logic     inv_init;
    logic     inv_src_b;
    logic     inv_mul;
    logic     inv_upd;
    logic     inv_fin;
    mm_step_e mm_step;
    mm_src_e  mm_src;
    logic     pow_init;
    logic     ld_base_inv;
    logic     ld_acc_mm;
    logic     ld_base_mm;
    logic     e_shift;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic m_zero;
    logic div_busy;
    logic r_zero;
    logic e_zero;
    logic e_lsb;
    logic wide_neg;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/mau_div.sv -----
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle. Narrow mode divides a residue-wide dividend,
// wide mode a full 64-bit dividend. Busy while the count runs.
// ----------------------------------------------------------------------------
module mau_div import mau_pkg::*; #(
  parameter int RESIDUE_BITS = 31
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    wide_i,
  input  logic [WIDE_W-1:0]       dividend_i,
  input  logic [RESIDUE_BITS-1:0] divisor_i,
  output logic                    busy_o,
  output logic [RESIDUE_BITS-1:0] quot_o,
  output logic [RESIDUE_BITS-1:0] rem_o
);

  localparam int W     = RESIDUE_BITS;
  localparam int CNT_W = $clog2(WIDE_W + 1);

  logic [CNT_W-1:0]  cnt_q;
  logic [WIDE_W-1:0] sh_q;
  logic [W-1:0]      rem_q;
  logic [W-1:0]      d_q;
  logic [W:0]        trial;
  logic              ge;

  // Shift in the next dividend bit and try the subtraction.
  assign trial = {rem_q, sh_q[WIDE_W-1]};
  assign ge    = trial >= {1'b0, d_q};

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= wide_i ? CNT_W'(WIDE_W) : CNT_W'(W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= wide_i ? dividend_i : (dividend_i << (WIDE_W - W));
      rem_q <= '0;
      d_q   <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? W'(trial - {1'b0, d_q}) : trial[W-1:0];
      sh_q  <= {sh_q[WIDE_W-2:0], ge};
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = sh_q[W-1:0];
  assign rem_o  = rem_q;

endmodule

// ----- rtl/mau_dp.sv -----
// ----------------------------------------------------------------------------
// Modular arithmetic datapath
// Configuration registers, operand registers, the simple residue ALU, the
// Euclid registers, the shared 32x32 multiplier with the Barrett steps, the
// power registers and the output register.
// ----------------------------------------------------------------------------
module mau_dp import mau_pkg::*; #(
  parameter int RESIDUE_BITS = 31
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  input  logic [OPC_W-1:0]         opcode_i,
  input  logic [FIELD_W-1:0]       operand_a_i,
  input  logic [FIELD_W-1:0]       operand_b_i,
  input  logic signed [WIDE_W-1:0] wide_operand_i,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [FIELD_W-1:0]       result_o
);

  localparam int W  = RESIDUE_BITS;
  localparam int SW = RESIDUE_BITS + 2;

  // Configuration and item registers.
  logic [FIELD_W-1:0] modulus_q;
  logic [CFG_W-1:0]   barrett_q;
  logic [W-1:0]       m;
  op_e                op_q;
  logic [W-1:0]       a_raw_q, b_raw_q, a_q, b_q;
  logic [WIDE_W-1:0]  wide_q, mag;

  // Divider interface.
  logic [WIDE_W-1:0]  div_dividend;
  logic [W-1:0]       div_divisor, div_quot, div_rem;
  logic               div_wide, div_busy;

  // ALU and result.
  logic [W:0]         sum, sub_wrap;
  logic [W-1:0]       alu_res, wred, res_q, out_q, res_d;
  logic               out_valid_q;

  // Euclid registers.
  logic [W-1:0]         g_q, r_q, inv_q;
  logic signed [SW-1:0] ex_q, ey_q, prod_s, ey_t, ex_fix;
  logic [SW-1:0]        ey_abs;

  // Multiplier and Barrett registers.
  logic [MUL_W-1:0]     mul_x, mul_y;
  logic                 mul_en;
  logic [2*MUL_W-1:0]   prod_q, x_q, rr_q, rfix;
  logic [4*MUL_W-1:0]   bacc_q, bacc_add;
  logic [W-1:0]         src_a, src_b, mm_res_q;

  // Power registers.
  logic [WIDE_W-1:0]    e_q;
  logic [W-1:0]         acc_q, base_q;

  assign m   = modulus_q[W-1:0];
  assign mag = wide_q[WIDE_W-1] ? (WIDE_W'(0) - wide_q) : wide_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RST;
      barrett_q <= BARRETT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MODULUS) begin
        modulus_q <= cfg_wdata_i[FIELD_W-1:0];
      end else if (cfg_idx_i == CFG_BARRETT) begin
        barrett_q <= cfg_wdata_i;
      end
    end
  end

  // Divider operand selection.
  always_comb begin
    div_dividend = WIDE_W'(a_raw_q);
    div_divisor  = m;
    div_wide     = 1'b0;
    case (cmd_i.div_src)
      DIV_SRC_A:    div_dividend = WIDE_W'(a_raw_q);
      DIV_SRC_B:    div_dividend = WIDE_W'(b_raw_q);
      DIV_SRC_WIDE: begin
        div_dividend = mag;
        div_wide     = 1'b1;
      end
      DIV_SRC_EUC:  begin
        div_dividend = WIDE_W'(g_q);
        div_divisor  = r_q;
      end
      default:      div_dividend = WIDE_W'(a_raw_q);
    endcase
  end

  mau_div #(
    .RESIDUE_BITS(RESIDUE_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .wide_i    (div_wide),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .busy_o    (div_busy),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // Combinational residue operations.
  assign sum      = {1'b0, a_q} + {1'b0, b_q};
  assign sub_wrap = {1'b0, a_q} + {1'b0, m} - {1'b0, b_q};

  always_comb begin
    alu_res = '0;
    case (op_q)
      OP_ADD:  alu_res = (sum >= {1'b0, m}) ? W'(sum - {1'b0, m}) : sum[W-1:0];
      OP_SUB:  alu_res = (a_q >= b_q) ? (a_q - b_q) : sub_wrap[W-1:0];
      OP_NEG:  alu_res = (a_q == '0) ? '0 : (m - a_q);
      OP_INC:  alu_res = (a_q == (m - 1'b1)) ? '0 : (a_q + 1'b1);
      OP_DEC:  alu_res = (a_q == '0) ? (m - 1'b1) : (a_q - 1'b1);
      default: alu_res = '0;
    endcase
  end

  // Sign fix of the wide reduction.
  assign wred = (wide_q[WIDE_W-1] && div_rem != '0) ? (m - div_rem) : div_rem;

  // Euclid coefficient update terms.
  assign prod_s = signed'(prod_q[SW-1:0]);
  assign ey_abs = ey_q[SW-1] ? SW'(-ey_q) : SW'(ey_q);
  assign ey_t   = ey_q[SW-1] ? (ex_q + prod_s) : (ex_q - prod_s);
  assign ex_fix = ex_q[SW-1] ? (ex_q + signed'(SW'(m))) : ex_q;

  // Modular multiplication operand pair.
  always_comb begin
    src_a = a_q;
    src_b = b_q;
    case (cmd_i.mm_src)
      MM_SRC_AB:   begin src_a = a_q;    src_b = b_q;    end
      MM_SRC_AINV: begin src_a = a_q;    src_b = inv_q;  end
      MM_SRC_ACCB: begin src_a = acc_q;  src_b = base_q; end
      MM_SRC_BB:   begin src_a = base_q; src_b = base_q; end
      default:     begin src_a = a_q;    src_b = b_q;    end
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_x  = '0;
    mul_y  = '0;
    mul_en = 1'b1;
    case (cmd_i.mm_step)
      MM_P0: begin mul_x = MUL_W'(src_a);       mul_y = MUL_W'(src_b);  end
      MM_L0: begin mul_x = barrett_q[31:0];     mul_y = x_q[31:0];      end
      MM_L1: begin mul_x = barrett_q[63:32];    mul_y = x_q[31:0];      end
      MM_L2: begin mul_x = barrett_q[31:0];     mul_y = x_q[63:32];     end
      MM_L3: begin mul_x = barrett_q[63:32];    mul_y = x_q[63:32];     end
      MM_Q0: begin mul_x = bacc_q[95:64];       mul_y = MUL_W'(m);      end
      MM_Q1: begin mul_x = bacc_q[127:96];      mul_y = MUL_W'(m);      end
      default: begin
        mul_x  = MUL_W'(div_quot);
        mul_y  = MUL_W'(ey_abs);
        mul_en = cmd_i.inv_mul;
      end
    endcase
  end

  // Shifted partial product for the high-half accumulation.
  always_comb begin
    bacc_add = '0;
    case (cmd_i.mm_step)
      MM_L1:   bacc_add = {64'd0, prod_q};
      MM_L2:   bacc_add = {32'd0, prod_q, 32'd0};
      MM_L3:   bacc_add = {32'd0, prod_q, 32'd0};
      MM_L4:   bacc_add = {prod_q, 64'd0};
      default: bacc_add = '0;
    endcase
  end

  assign rfix = (rr_q >= (2*MUL_W)'(m)) ? (rr_q - (2*MUL_W)'(m)) : rr_q;

  // Result source selection.
  always_comb begin
    res_d = '0;
    case (cmd_i.res_src)
      RES_ZERO: res_d = '0;
      RES_ALU:  res_d = alu_res;
      RES_WRED: res_d = wred;
      RES_INV:  res_d = inv_q;
      RES_MM:   res_d = mm_res_q;
      RES_ACC:  res_d = acc_q;
      default:  res_d = '0;
    endcase
  end

  // Datapath payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      op_q    <= op_e'(opcode_i);
      a_raw_q <= operand_a_i[W-1:0];
      b_raw_q <= operand_b_i[W-1:0];
      wide_q  <= wide_operand_i;
    end
    if (cmd_i.ld_a) a_q <= div_rem;
    if (cmd_i.ld_b) b_q <= div_rem;
    if (cmd_i.res_ld) res_q <= res_d;

    // Euclid steps.
    if (cmd_i.inv_init) begin
      g_q  <= m;
      r_q  <= cmd_i.inv_src_b ? b_q : a_q;
      ex_q <= '0;
      ey_q <= SW'(1);
    end else if (cmd_i.inv_upd) begin
      g_q  <= r_q;
      r_q  <= div_rem;
      ex_q <= ey_q;
      ey_q <= ey_t;
    end
    if (cmd_i.inv_fin) inv_q <= ex_fix[W-1:0];

    // Multiplier and Barrett steps.
    if (mul_en) prod_q <= mul_x * mul_y;
    if (cmd_i.mm_step == MM_X) x_q <= prod_q;
    if (cmd_i.mm_step == MM_L0) begin
      bacc_q <= '0;
    end else if (cmd_i.mm_step == MM_L1 || cmd_i.mm_step == MM_L2 ||
                 cmd_i.mm_step == MM_L3 || cmd_i.mm_step == MM_L4) begin
      bacc_q <= bacc_q + bacc_add;
    end
    if (cmd_i.mm_step == MM_Q1) rr_q <= x_q - prod_q;
    if (cmd_i.mm_step == MM_Q2) rr_q <= rr_q - {prod_q[31:0], 32'd0};
    if (cmd_i.mm_step == MM_FIN) mm_res_q <= rfix[W-1:0];

    // Power registers.
    if (cmd_i.pow_init) begin
      e_q    <= mag;
      acc_q  <= (m == W'(1)) ? '0 : W'(1);
      base_q <= a_q;
    end else begin
      if (cmd_i.e_shift) e_q <= e_q >> 1;
      if (cmd_i.ld_acc_mm) acc_q <= mm_res_q;
      if (cmd_i.ld_base_inv) begin
        base_q <= inv_q;
      end else if (cmd_i.ld_base_mm) begin
        base_q <= mm_res_q;
      end
    end

    if (cmd_i.out_ld) out_q <= res_q;
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Status to the controller.
  always_comb begin
    sts_o          = '0;
    sts_o.op       = op_q;
    sts_o.m_zero   = m == '0;
    sts_o.div_busy = div_busy;
    sts_o.r_zero   = r_q == '0;
    sts_o.e_zero   = e_q == '0;
    sts_o.e_lsb    = e_q[0];
    sts_o.wide_neg = wide_q[WIDE_W-1];
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = FIELD_W'(out_q);

endmodule

// ----- rtl/mau_ctrl.sv -----
// ----------------------------------------------------------------------------
// Modular arithmetic controller
// Sequences operand reduction, the operation, the Euclid loop, the Barrett
// multiplication steps and the power loop, then hands the beat to the
// output register.
// ----------------------------------------------------------------------------
module mau_ctrl import mau_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_DA, S_DB, S_DISP, S_DW,
    S_IDIV, S_IWAIT, S_IUPD, S_IFIN, S_IRET,
    S_PCHK, S_PSH, S_PSQ,
    S_MP0, S_MX, S_ML0, S_ML1, S_ML2, S_ML3, S_ML4,
    S_MQ0, S_MQ1, S_MQ2, S_MFIN, S_MRET,
    S_FINISH
  } state_e;

  typedef enum logic [1:0] {
    RET_RES,
    RET_ACC,
    RET_BASE
  } ret_e;

  state_e  state_q, state_d;
  mm_src_e mm_src_q, mm_src_d;
  ret_e    ret_q, ret_d;

  // Next state and command decode.
  always_comb begin
    state_d  = state_q;
    mm_src_d = mm_src_q;
    ret_d    = ret_q;
    cmd_o    = '0;
    cmd_o.mm_src = mm_src_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.ld_in = in_valid_i;
        if (in_valid_i) state_d = S_CHK;
      end
      S_CHK: begin
        if (sts_i.m_zero) begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_src = RES_ZERO;
          state_d       = S_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = DIV_SRC_A;
          state_d         = S_DA;
        end
      end
      S_DA: begin
        cmd_o.div_src = DIV_SRC_A;
        if (!sts_i.div_busy) begin
          cmd_o.ld_a      = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = DIV_SRC_B;
          state_d         = S_DB;
        end
      end
      S_DB: begin
        if (!sts_i.div_busy) begin
          cmd_o.ld_b = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.op)
          OP_REDUCE: begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_src   = DIV_SRC_WIDE;
            state_d         = S_DW;
          end
          OP_ADD, OP_SUB, OP_NEG, OP_INC, OP_DEC: begin
            cmd_o.res_ld  = 1'b1;
            cmd_o.res_src = RES_ALU;
            state_d       = S_FINISH;
          end
          OP_MUL: begin
            mm_src_d = MM_SRC_AB;
            ret_d    = RET_RES;
            state_d  = S_MP0;
          end
          OP_DIV: begin
            cmd_o.inv_init  = 1'b1;
            cmd_o.inv_src_b = 1'b1;
            state_d         = S_IDIV;
          end
          OP_INV: begin
            cmd_o.inv_init = 1'b1;
            state_d        = S_IDIV;
          end
          OP_POW: begin
            cmd_o.pow_init = 1'b1;
            if (sts_i.wide_neg) begin
              cmd_o.inv_init = 1'b1;
              state_d        = S_IDIV;
            end else begin
              state_d = S_PCHK;
            end
          end
          default: begin
            cmd_o.res_ld  = 1'b1;
            cmd_o.res_src = RES_ZERO;
            state_d       = S_FINISH;
          end
        endcase
      end
      S_DW: begin
        if (!sts_i.div_busy) begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_src = RES_WRED;
          state_d       = S_FINISH;
        end
      end
      // Euclid loop: divide, multiply the quotient, update coefficients.
      S_IDIV: begin
        if (sts_i.r_zero) begin
          state_d = S_IFIN;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = DIV_SRC_EUC;
          state_d         = S_IWAIT;
        end
      end
      S_IWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.inv_mul = 1'b1;
          state_d       = S_IUPD;
        end
      end
      S_IUPD: begin
        cmd_o.inv_upd = 1'b1;
        state_d       = S_IDIV;
      end
      S_IFIN: begin
        cmd_o.inv_fin = 1'b1;
        state_d       = S_IRET;
      end
      S_IRET: begin
        case (sts_i.op)
          OP_DIV: begin
            mm_src_d = MM_SRC_AINV;
            ret_d    = RET_RES;
            state_d  = S_MP0;
          end
          OP_POW: begin
            cmd_o.ld_base_inv = 1'b1;
            state_d           = S_PCHK;
          end
          default: begin
            cmd_o.res_ld  = 1'b1;
            cmd_o.res_src = RES_INV;
            state_d       = S_FINISH;
          end
        endcase
      end
      // Square-and-multiply over the exponent bits.
      S_PCHK: begin
        if (sts_i.e_zero) begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_src = RES_ACC;
          state_d       = S_FINISH;
        end else if (sts_i.e_lsb) begin
          mm_src_d = MM_SRC_ACCB;
          ret_d    = RET_ACC;
          state_d  = S_MP0;
        end else begin
          state_d = S_PSH;
        end
      end
      S_PSH: begin
        cmd_o.e_shift = 1'b1;
        state_d       = S_PSQ;
      end
      S_PSQ: begin
        if (sts_i.e_zero) begin
          state_d = S_PCHK;
        end else begin
          mm_src_d = MM_SRC_BB;
          ret_d    = RET_BASE;
          state_d  = S_MP0;
        end
      end
      // Barrett modular multiplication steps.
      S_MP0:  begin cmd_o.mm_step = MM_P0;  state_d = S_MX;   end
      S_MX:   begin cmd_o.mm_step = MM_X;   state_d = S_ML0;  end
      S_ML0:  begin cmd_o.mm_step = MM_L0;  state_d = S_ML1;  end
      S_ML1:  begin cmd_o.mm_step = MM_L1;  state_d = S_ML2;  end
      S_ML2:  begin cmd_o.mm_step = MM_L2;  state_d = S_ML3;  end
      S_ML3:  begin cmd_o.mm_step = MM_L3;  state_d = S_ML4;  end
      S_ML4:  begin cmd_o.mm_step = MM_L4;  state_d = S_MQ0;  end
      S_MQ0:  begin cmd_o.mm_step = MM_Q0;  state_d = S_MQ1;  end
      S_MQ1:  begin cmd_o.mm_step = MM_Q1;  state_d = S_MQ2;  end
      S_MQ2:  begin cmd_o.mm_step = MM_Q2;  state_d = S_MFIN; end
      S_MFIN: begin cmd_o.mm_step = MM_FIN; state_d = S_MRET; end
      S_MRET: begin
        case (ret_q)
          RET_ACC: begin
            cmd_o.ld_acc_mm = 1'b1;
            state_d         = S_PSH;
          end
          RET_BASE: begin
            cmd_o.ld_base_mm = 1'b1;
            state_d          = S_PCHK;
          end
          default: begin
            cmd_o.res_ld  = 1'b1;
            cmd_o.res_src = RES_MM;
            state_d       = S_FINISH;
          end
        endcase
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and sequencing registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mm_src_q <= MM_SRC_AB;
      ret_q    <= RET_RES;
    end else begin
      state_q  <= state_d;
      mm_src_q <= mm_src_d;
      ret_q    <= ret_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

// ----- rtl/modular_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Residue add, subtract, multiply, divide, negate, increment, decrement,
// inverse, power and signed reduction, with Barrett multiplication.
//
//   Channel  | Handshake                   | Payload
//   ---------+-----------------------------+-----------------------------------
//   input    | in_valid_i / in_ready_o     | opcode, operand_a/b, wide_operand
//   output   | out_valid_o / out_ready_i   | result
//   config   | cfg_we_i (no wait)          | cfg_idx_i, cfg_wdata_i
//
// One beat at a time. Operand reduction runs on the bit-serial divider, as
// do reduce, with its wide division, and each Euclid step. A modular
// multiply runs on the shared 32x32 multiplier; power costs one or two
// multiplies per exponent bit, and a negative exponent runs the inverse
// first. Reset clears the controller and the output flag and loads the
// default modulus. A finished result waits in the output register, and the
// next beat is taken while it waits.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit import mau_pkg::*; #(
  parameter int RESIDUE_BITS = 31
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OPC_W-1:0]         opcode_i,
  input  logic [FIELD_W-1:0]       operand_a_i,
  input  logic [FIELD_W-1:0]       operand_b_i,
  input  logic signed [WIDE_W-1:0] wide_operand_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [FIELD_W-1:0]       result_o
);

  cmd_t cmd;
  sts_t sts;

  mau_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mau_dp #(
    .RESIDUE_BITS(RESIDUE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (opcode_i),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .wide_operand_i(wide_operand_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_o      (result_o)
  );

endmodule

// ----- rtl/mau_chk.sv -----
// ----------------------------------------------------------------------------
// Modular arithmetic unit checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module mau_chk import mau_pkg::*; #(
  parameter int RESIDUE_BITS = 31
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [FIELD_W-1:0] result_o
);

  // A stalled result beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(result_o))
    else $error("result changed while stalled");

  // The unit works on one beat at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // Results never carry bits above the residue width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_o >> RESIDUE_BITS) == '0)
    else $error("result wider than a residue");

endmodule

bind modular_arithmetic_unit mau_chk #(
  .RESIDUE_BITS(RESIDUE_BITS)
) u_mau_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .result_o   (result_o)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit testbench
// Drives opcode and operand beats through the valid/ready input channel,
// predicts each residue in software from the current modulus and Barrett
// factor, and compares every output beat with the oldest expected residue.
// ----------------------------------------------------------------------------
module tb;
  import mau_pkg::*;

  localparam int          RB       = 31;
  localparam logic [63:0] RMASK    = (64'd1 << RB) - 64'd1;
  localparam int          LIMIT    = 40000000;
  localparam int          N_RANDOM = 1900;
  localparam int          DRAIN    = 4000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [OPC_W-1:0]  opcode_i = '0;
  logic [FIELD_W-1:0] operand_a_i = '0;
  logic [FIELD_W-1:0] operand_b_i = '0;
  logic signed [WIDE_W-1:0] wide_operand_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [FIELD_W-1:0] result_o;

  modular_arithmetic_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor copy of the configuration.
  logic [63:0] mod_q;
  logic [63:0] bfac_q;

  // Expected residues, oldest first.
  logic [FIELD_W-1:0] residue_q[$];

  int  n_err = 0;
  int  cycles = 0;
  int  send_idle = 17;
  int  recv_idle = 72;
  bit  hold_off = 1'b0;

  // Barrett reduction of a 62-bit product.
  function automatic logic [63:0] barrett(input logic [63:0] x, input logic [63:0] m);
    logic [127:0] prod;
    logic [63:0]  r;
    prod = bfac_q * x;
    r = x - prod[127:64] * m;
    if (r >= m) r = r - m;
    return r & RMASK;
  endfunction

  function automatic logic [63:0] mulmod(input logic [63:0] a, input logic [63:0] b,
                                         input logic [63:0] m);
    return barrett((a & RMASK) * (b & RMASK), m);
  endfunction

  // Extended Euclid, keeping the coefficient as the steps leave it.
  function automatic logic [63:0] invmod(input logic [63:0] a, input logic [63:0] m);
    longint g, r, x, y, q, t;
    g = m; r = a; x = 0; y = 1;
    while (r != 0) begin
      q = g / r;
      t = g % r;
      g = r;
      r = t;
      t = x - q * y;
      x = y;
      y = t;
    end
    if (x < 0) x = x + longint'(m);
    return 64'(x) & RMASK;
  endfunction

  function automatic logic [63:0] powmod(input logic [63:0] a, input logic [63:0] ex,
                                         input logic [63:0] m);
    logic [63:0] e, base, acc;
    e = ex; base = a; acc = 64'd1 % m;
    if (ex[63]) begin
      e = 64'd0 - ex;
      base = invmod(a, m);
    end
    while (e > 0) begin
      if (e[0]) acc = mulmod(acc, base, m);
      e = e >> 1;
      if (e > 0) base = mulmod(base, base, m);
    end
    return acc;
  endfunction

  function automatic logic [FIELD_W-1:0] residue_of(input logic [3:0] op,
      input logic [30:0] ia, input logic [30:0] ib, input logic [63:0] w);
    logic [63:0] m, a, b, res, mag;
    m = mod_q & RMASK;
    if (m == 0) return '0;
    a = (64'(ia) & RMASK) % m;
    b = (64'(ib) & RMASK) % m;
    res = 0;
    case (op)
      OP_REDUCE: begin
        mag = w[63] ? 64'd0 - w : w;
        res = mag % m;
        if (w[63] && res != 0) res = m - res;
      end
      OP_ADD: begin
        res = a + b;
        if (res >= m) res = res - m;
      end
      OP_SUB: res = (a >= b) ? a - b : a + m - b;
      OP_MUL: res = mulmod(a, b, m);
      OP_DIV: res = mulmod(a, invmod(b, m), m);
      OP_NEG: res = (a == 0) ? 0 : m - a;
      OP_INC: res = (a == m - 1) ? 0 : a + 1;
      OP_DEC: res = (a == 0) ? m - 1 : a - 1;
      OP_INV: res = invmod(a, m);
      OP_POW: res = powmod(a, w, m);
      default: res = 0;
    endcase
    return FIELD_W'(res & RMASK);
  endfunction

  // Result checking at the rising edge.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (residue_q.size() == 0) begin
        n_err <= n_err + 1;
        if (n_err < 10) $display("ERROR: unexpected result %0d", result_o);
      end else begin
        if (result_o !== residue_q[0]) begin
          n_err <= n_err + 1;
          if (n_err < 10)
            $display("ERROR: result expected %0d actual %0d", residue_q[0], result_o);
        end
        void'(residue_q.pop_front());
      end
    end
  end

  // Receiver readiness, changed at the falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (cycles >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_MODULUS) mod_q = val & ((64'd1 << 31) - 1);
    else bfac_q = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Set a modulus with its matching Barrett factor.
  task automatic set_modulus(input logic [63:0] m);
    write_reg(CFG_MODULUS, m);
    write_reg(CFG_BARRETT, (m == 0) ? 64'd1 : 64'hFFFF_FFFF_FFFF_FFFF / m);
  endtask

  // Offer one beat and hold it until accepted; optional expected residue.
  // Valid stays high after acceptance so the next beat can follow at once.
  task automatic send_beat(input logic [3:0] op, input logic [30:0] a, input logic [30:0] b,
                           input logic [63:0] w, input bit typed, input logic [30:0] want);
    logic [30:0] pred;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    wide_operand_i <= w;
    pred = residue_of(op, a, b, w);
    if (typed && pred !== want)
      $display("ERROR: table entry expects %0d, predictor gives %0d", want, pred);
    residue_q.push_back(typed ? want : pred);
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (residue_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  function automatic logic [30:0] rnd_res(input logic [63:0] m);
    case ($urandom_range(5))
      0: return 31'd0;
      1: return (m > 1) ? 31'(m - 1) : 31'd0;
      2: return 31'($urandom);
      default: return (m > 0) ? 31'($urandom % m) : 31'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rnd_exp();
    case ($urandom_range(4))
      0: return 64'($urandom_range(20)) - 64'd10;
      1: return {$urandom, $urandom};
      2: return 64'($signed($urandom));
      default: return 64'($urandom_range(65535));
    endcase
  endfunction

  // Directed table: expected residue typed in where it is obvious.
  typedef struct {
    logic [3:0]  op;
    logic [30:0] a;
    logic [30:0] b;
    logic [63:0] w;
    bit          typed;
    logic [30:0] want;
  } row_t;

  localparam logic [30:0] M0 = 31'd1000000007;

  row_t dir_tbl[] = '{
    '{OP_REDUCE, 31'd0, 31'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 31'd0},
    '{OP_REDUCE, 31'd0, 31'd0, 64'h8000_0000_0000_0000, 1'b0, 31'd0},
    '{OP_REDUCE, 31'd0, 31'd0, -64'sd1, 1'b1, M0 - 31'd1},
    '{OP_ADD, M0 - 31'd1, 31'd1, 64'd0, 1'b1, 31'd0},
    '{OP_SUB, 31'd0, 31'd1, 64'd0, 1'b1, M0 - 31'd1},
    '{OP_MUL, M0 - 31'd1, M0 - 31'd1, 64'd0, 1'b1, 31'd1},
    '{OP_DIV, 31'd5, 31'd1, 64'd0, 1'b1, 31'd5},
    '{OP_DIV, 31'd7, 31'd0, 64'd0, 1'b1, 31'd0},
    '{OP_NEG, 31'd0, 31'd0, 64'd0, 1'b1, 31'd0},
    '{OP_INC, M0 - 31'd1, 31'd0, 64'd0, 1'b1, 31'd0},
    '{OP_DEC, 31'd0, 31'd0, 64'd0, 1'b1, M0 - 31'd1},
    '{OP_INV, 31'd0, 31'd0, 64'd0, 1'b1, 31'd0},
    '{OP_INV, 31'd1, 31'd0, 64'd0, 1'b1, 31'd1},
    '{OP_POW, 31'd3, 31'd0, 64'd0, 1'b1, 31'd1},
    '{OP_POW, 31'd2, 31'd0, 64'd10, 1'b1, 31'd1024},
    '{OP_POW, 31'd2, 31'd0, -64'sd1, 1'b0, 31'd0},
    '{OP_POW, 31'd3, 31'd0, 64'h8000_0000_0000_0000, 1'b0, 31'd0},
    '{OP_ADD, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 64'd0, 1'b0, 31'd0},
    '{4'd10, 31'd5, 31'd5, 64'd0, 1'b1, 31'd0},
    '{4'd15, 31'd5, 31'd5, 64'd0, 1'b1, 31'd0}
  };

  // Random beats under the current configuration.
  task automatic random_beats(input int count);
    logic [3:0] op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
      send_beat(op, rnd_res(mod_q), rnd_res(mod_q),
                (op == OP_POW) ? rnd_exp() : {$urandom, $urandom}, 1'b0, '0);
    end
  endtask

  // Long receiver hold-off while the sender keeps offering beats.
  initial begin
    repeat (300) @(negedge clk_i);
    hold_off = 1'b1;
    repeat (3000) @(negedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    mod_q = 64'(MODULUS_RST);
    bfac_q = BARRETT_RST;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tbl[i])
      send_beat(dir_tbl[i].op, dir_tbl[i].a, dir_tbl[i].b, dir_tbl[i].w,
                dir_tbl[i].typed, dir_tbl[i].want);
    random_beats(200);
    wait_idle();

    // Small and extreme moduli, then an inconsistent Barrett factor.
    set_modulus(64'd1);
    random_beats(40);
    wait_idle();
    set_modulus(64'd0);
    random_beats(40);
    wait_idle();
    set_modulus(64'd2);
    random_beats(60);
    wait_idle();
    set_modulus(64'h7FFF_FFFF);
    random_beats(300);
    wait_idle();

    send_idle = 72;
    recv_idle = 17;
    set_modulus(64'd97);
    random_beats(300);
    wait_idle();
    set_modulus(64'd1000);
    random_beats(200);
    wait_idle();
    write_reg(CFG_BARRETT, 64'hFFFF_FFFF_FFFF_FFFF);
    random_beats(100);
    wait_idle();
    write_reg(CFG_BARRETT, 64'd1);
    random_beats(60);
    wait_idle();

    send_idle = 0;
    recv_idle = 0;
    set_modulus(64'(32'($urandom_range(2147483647, 3))));
    random_beats(400);
    wait_idle();
    set_modulus(64'd998244353);
    random_beats(200);
    wait_idle();

    if (n_err == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ----- modular_arithmetic_unit.f -----
rtl/mau_pkg.sv
rtl/mau_div.sv
rtl/mau_dp.sv
rtl/mau_ctrl.sv
rtl/modular_arithmetic_unit.sv
rtl/mau_chk.sv
tb/sv/tb.sv
